// ===== rtl/fixed_block_pool_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Shared property macros for the checker of the allocator unit.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBPA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBPA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Widths, register map, status codes and reset values of the allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int unsigned DEFAULT_MAX_BLOCKS = 1024;

    localparam int ADDR_W        = 32;
    localparam int BLK_BYTES_W   = 16;
    localparam int POOL_BLOCKS_W = 11;
    localparam int STATUS_W      = 3;
    localparam int MUL_A_W       = 16;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;
    localparam int REG_IDX_W     = 2;

    localparam logic [REG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_POOL_BLOCKS = 2'd2;

    localparam logic [ADDR_W-1:0]        RST_POOL_BASE   = 32'd4096;
    localparam logic [BLK_BYTES_W-1:0]   RST_BLOCK_BYTES = 16'd64;
    localparam logic [POOL_BLOCKS_W-1:0] RST_POOL_BLOCKS = 11'd0;

    localparam logic [STATUS_W-1:0] ST_REUSED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FRESH       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREE_OK     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREE_REJECT = 3'd4;

endpackage

// ===== rtl/fixed_block_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator unit
// Hands out and takes back fixed-size blocks of a configured address region,
// reusing freed blocks from a LIFO stack held in RAM before fresh ones.
// ----------------------------------------------------------------------------
// The unit works on one request word at a time. An allocate that hands out a
// block goes through the stack RAM read, index times block size, base add and
// output load. A free that reaches the stack passes the region test, then the
// restoring divider that finds the block index and checks alignment one quotient
// bit per cycle, then the push. An allocate that falls back and a free refused
// before the region test go straight to the output load, and a free outside the
// region goes from the region test to the output load. A result still waiting
// in the output register holds the unit in its last step until it is taken.
// The input is ready again once the result is loaded into the output register.
// No clearing pass follows reset: stack entries are only read below the stack
// depth.
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = DEFAULT_MAX_BLOCKS
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ADDR_W-1:0]   s_tdata,    // [31:0] free_address
    input  logic                s_tuser,    // [0] mode

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ADDR_W-1:0]   m_tdata,    // [31:0] block_address
    output logic [STATUS_W-1:0] m_tuser,    // [2:0] status

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int Q_W    = (IDX_W < POOL_BLOCKS_W) ? IDX_W : POOL_BLOCKS_W;
    localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_RANGE,
        S_CMP,
        S_DIV,
        S_PUSH,
        S_DONE
    } state_t;

    logic [ADDR_W-1:0]        pool_base_reg;
    logic [BLK_BYTES_W-1:0]   block_bytes_reg;
    logic [POOL_BLOCKS_W-1:0] pool_blocks_reg;

    state_t                   state_reg,      state_next;
    logic [POOL_BLOCKS_W-1:0] fresh_cnt_reg,  fresh_cnt_next;
    logic [POOL_BLOCKS_W-1:0] depth_reg,      depth_next;
    logic [POOL_BLOCKS_W-1:0] fresh_idx_reg,  fresh_idx_next;
    logic                     pop_reg,        pop_next;
    logic [ADDR_W-1:0]        addr_reg,       addr_next;
    logic [ADDR_W-1:0]        mul_reg,        mul_next;
    logic [ADDR_W-1:0]        rem_reg,        rem_next;
    logic [Q_W-1:0]           quot_reg,       quot_next;
    logic [STEP_W-1:0]        step_reg,       step_next;
    logic [STATUS_W-1:0]      status_reg,     status_next;
    logic [ADDR_W-1:0]        res_reg,        res_next;
    logic                     m_tvalid_reg,   m_tvalid_next;
    logic [ADDR_W-1:0]        m_tdata_reg,    m_tdata_next;
    logic [STATUS_W-1:0]      m_tuser_reg,    m_tuser_next;

    logic [POOL_BLOCKS_W-1:0] total;
    logic [POOL_BLOCKS_W-1:0] pop_ptr;
    logic [MUL_A_W-1:0]       mul_a;
    logic [ADDR_W-1:0]        mul_prod;
    logic [ADDR_W:0]          region_end;
    logic [ADDR_W-1:0]        div_trial;
    logic                     cfg_wr;
    logic [REG_IDX_W-1:0]     reg_idx;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [IDX_W-1:0]         ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [IDX_W-1:0]         ram_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg   <= RST_POOL_BASE;
            block_bytes_reg <= RST_BLOCK_BYTES;
            pool_blocks_reg <= RST_POOL_BLOCKS;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_POOL_BASE:   pool_base_reg   <= pwdata;
                REG_BLOCK_BYTES: block_bytes_reg <= pwdata[BLK_BYTES_W-1:0];
                REG_POOL_BLOCKS: pool_blocks_reg <= pwdata[POOL_BLOCKS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_POOL_BASE:   prdata = pool_base_reg;
            REG_BLOCK_BYTES: prdata = PDATA_W'(block_bytes_reg);
            REG_POOL_BLOCKS: prdata = PDATA_W'(pool_blocks_reg);
            default:         prdata = '0;
        endcase
    end

    assign total = (32'(pool_blocks_reg) > MAX_BLOCKS) ? POOL_BLOCKS_W'(MAX_BLOCKS)
                                                       : pool_blocks_reg;

    assign pop_ptr   = depth_reg - 1'b1;
    assign ram_raddr = IDX_W'(pop_ptr);
    assign ram_waddr = IDX_W'(depth_reg);
    assign ram_wdata = IDX_W'(quot_reg);
    assign ram_we    = (state_reg == S_PUSH) && (rem_reg == '0) && (depth_reg < total);

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (state_reg == S_RANGE) begin
            mul_a = MUL_A_W'(total);
        end else if (pop_reg) begin
            mul_a = MUL_A_W'(ram_rdata);
        end else begin
            mul_a = MUL_A_W'(fresh_idx_reg);
        end
    end

    assign mul_prod   = {16'd0, mul_a} * {16'd0, block_bytes_reg};
    assign region_end = {1'b0, pool_base_reg} + {1'b0, mul_reg};
    assign div_trial  = {16'd0, block_bytes_reg} << step_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next     = state_reg;
        fresh_cnt_next = fresh_cnt_reg;
        depth_next     = depth_reg;
        fresh_idx_next = fresh_idx_reg;
        pop_next       = pop_reg;
        addr_next      = addr_reg;
        mul_next       = mul_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    res_next = '0;
                    if (!s_tuser) begin
                        if (total == '0) begin
                            status_next = ST_EXHAUSTED;
                            state_next  = S_DONE;
                        end else if (depth_reg != '0) begin
                            depth_next  = pop_ptr;
                            pop_next    = 1'b1;
                            status_next = ST_REUSED;
                            state_next  = S_MUL;
                        end else if (fresh_cnt_reg < total) begin
                            fresh_idx_next = fresh_cnt_reg;
                            fresh_cnt_next = fresh_cnt_reg + 1'b1;
                            pop_next       = 1'b0;
                            status_next    = ST_FRESH;
                            state_next     = S_MUL;
                        end else begin
                            status_next = ST_EXHAUSTED;
                            state_next  = S_DONE;
                        end
                    end else begin
                        addr_next = s_tdata;
                        if ((total != '0) && (s_tdata != '0) && (block_bytes_reg != '0)
                                && (s_tdata >= pool_base_reg)) begin
                            state_next = S_RANGE;
                        end else begin
                            status_next = ST_FREE_REJECT;
                            state_next  = S_DONE;
                        end
                    end
                end
            end
            S_MUL: begin
                mul_next   = mul_prod;
                state_next = S_ADD;
            end
            S_ADD: begin
                res_next   = pool_base_reg + mul_reg;
                state_next = S_DONE;
            end
            S_RANGE: begin
                mul_next   = mul_prod;
                state_next = S_CMP;
            end
            S_CMP: begin
                if ({1'b0, addr_reg} < region_end) begin
                    rem_next   = addr_reg - pool_base_reg;
                    quot_next  = '0;
                    step_next  = STEP_W'(Q_W - 1);
                    state_next = S_DIV;
                end else begin
                    status_next = ST_FREE_REJECT;
                    state_next  = S_DONE;
                end
            end
            S_DIV: begin
                if (rem_reg >= div_trial) begin
                    rem_next            = rem_reg - div_trial;
                    quot_next[step_reg] = 1'b1;
                end
                if (step_reg == '0) begin
                    state_next = S_PUSH;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_PUSH: begin
                if (ram_we) begin
                    depth_next  = depth_reg + 1'b1;
                    status_next = ST_FREE_OK;
                end else begin
                    status_next = ST_FREE_REJECT;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tuser_next  = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fresh_cnt_reg <= '0;
            depth_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fresh_cnt_reg <= fresh_cnt_next;
            depth_reg     <= depth_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        fresh_idx_reg <= fresh_idx_next;
        pop_reg       <= pop_next;
        addr_reg      <= addr_next;
        mul_reg       <= mul_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        step_reg      <= step_next;
        status_reg    <= status_next;
        res_reg       <= res_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

endmodule

// ===== rtl/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fbpa_checker.sv =====
// ----------------------------------------------------------------------------
// Fixed block pool allocator checker
// Port-level properties of the allocator unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_unit_defines.svh"

module fbpa_checker
    import fbpa_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [ADDR_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0] m_tuser
);

    // A stalled result word keeps its contents.
    `FBPA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // Fallbacks and every free report a zero address.
    `FBPA_ASSERT_IMP(a_zero_addr, aclk, aresetn, m_tvalid && (m_tuser == ST_EXHAUSTED || m_tuser == ST_FREE_OK || m_tuser == ST_FREE_REJECT), m_tdata == '0, "nonzero address on a fallback or free result")

    // The unit holds one request at a time.
    `FBPA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input ready right after accepting a request")

    // Every result word carries a defined status code.
    `FBPA_ASSERT_IMP(a_status_code, aclk, aresetn, m_tvalid, m_tuser <= ST_FREE_REJECT, "undefined status code on a result word")

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator unit testbench
// Drives allocate and free request words into the allocator under random
// backpressure and gaps. Each reply is compared with a cycle-free model of the
// pool kept in the bench. A directed table covers pool off, the region edges,
// a double free, a full stack, zero block size, address wrap and an oversized
// pool. Random phases then reprogram the pool and run mostly allocate and free
// sequences of handed-out addresses, with malformed frees mixed in.
// ----------------------------------------------------------------------------
module tb;
    import fbpa_pkg::*;

    localparam int unsigned MAX_BLOCKS = DEFAULT_MAX_BLOCKS;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 125;
    localparam int DIR_ROWS = 37;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
    } reply_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic                mode;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [31:0]         val;
        logic                typed;
        logic [ADDR_W-1:0]   exp_addr;
        logic [STATUS_W-1:0] exp_st;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [ADDR_W-1:0]   s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [ADDR_W-1:0]   m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    fixed_block_pool_allocator_unit #(.MAX_BLOCKS(MAX_BLOCKS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 aclk = ~aclk;

    // Bench copy of the pool.
    logic [ADDR_W-1:0]        cfg_base = RST_POOL_BASE;
    logic [BLK_BYTES_W-1:0]   cfg_bytes = RST_BLOCK_BYTES;
    logic [POOL_BLOCKS_W-1:0] cfg_blocks = RST_POOL_BLOCKS;
    int unsigned              fresh_cnt = 0;
    int unsigned              stk_depth = 0;
    logic [31:0]              free_stack [MAX_BLOCKS];

    reply_t            reply_q [$];
    logic [ADDR_W-1:0] owned_q [$];
    int                err_cnt = 0;
    int                n_items = 0;
    int                stat_cnt [5] = '{0, 0, 0, 0, 0};
    bit                tx_idle_on = 1'b0;
    bit                rx_idle_on = 1'b0;
    bit                hold_req = 1'b0;
    int                hold_left = 0;
    int                idle_left = 0;

    stim_row_t dir_tbl [DIR_ROWS] = '{
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b1, 32'd0, ST_EXHAUSTED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd4096, 1'b1, 32'd0, ST_FREE_REJECT},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd0, 1'b1, 32'd0, ST_FREE_REJECT},
        '{ROW_CFG, MODE_ALLOC, REG_POOL_BLOCKS, 32'd3, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b1, 32'd4096, ST_FRESH},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b1, 32'd4160, ST_FRESH},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b1, 32'd4224, ST_FRESH},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b1, 32'd0, ST_EXHAUSTED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd0, 1'b1, 32'd0, ST_FREE_REJECT},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd4128, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd4288, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd4095, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd4160, 1'b1, 32'd0, ST_FREE_OK},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd4160, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd4096, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd4224, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b1, 32'd0, ST_EXHAUSTED},
        '{ROW_CFG, MODE_ALLOC, REG_BLOCK_BYTES, 32'd0, 1'b0, 32'd0, ST_REUSED},
        '{ROW_CFG, MODE_ALLOC, REG_POOL_BLOCKS, 32'd5, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'd4096, 1'b1, 32'd0, ST_FREE_REJECT},
        '{ROW_CFG, MODE_ALLOC, REG_POOL_BASE, 32'hFFFF_FFFF, 1'b0, 32'd0, ST_REUSED},
        '{ROW_CFG, MODE_ALLOC, REG_BLOCK_BYTES, 32'd65535, 1'b0, 32'd0, ST_REUSED},
        '{ROW_CFG, MODE_ALLOC, REG_POOL_BLOCKS, 32'd2047, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'hFFFF_FFFF, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'hFFFF_FFFE, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'hFFFF_FFFF, 1'b0, 32'd0, ST_REUSED},
        '{ROW_CFG, MODE_ALLOC, REG_POOL_BLOCKS, 32'd0, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b1, 32'd0, ST_EXHAUSTED},
        '{ROW_ITEM, MODE_FREE, REG_POOL_BASE, 32'hFFFF_FFFF, 1'b1, 32'd0, ST_FREE_REJECT},
        '{ROW_CFG, MODE_ALLOC, REG_POOL_BLOCKS, 32'd1024, 1'b0, 32'd0, ST_REUSED},
        '{ROW_ITEM, MODE_ALLOC, REG_POOL_BASE, 32'd0, 1'b0, 32'd0, ST_REUSED}
    };

    function automatic int unsigned pool_total();
        return (int'(cfg_blocks) > int'(MAX_BLOCKS)) ? MAX_BLOCKS : int'(cfg_blocks);
    endfunction

    function automatic logic [ADDR_W-1:0] block_addr(input logic [31:0] idx);
        logic [63:0] sum;
        sum = {32'd0, cfg_base} + {32'd0, idx} * {48'd0, cfg_bytes};
        return sum[31:0];
    endfunction

    function automatic reply_t predict_pool_reply(input logic mode,
                                                  input logic [ADDR_W-1:0] addr);
        reply_t      r;
        int unsigned total;
        logic [63:0] region_end;
        logic [31:0] off;
        total = pool_total();
        r.addr = '0;
        r.status = ST_FREE_REJECT;
        if (mode == MODE_ALLOC) begin
            if (total == 0) begin
                r.status = ST_EXHAUSTED;
            end else if (stk_depth > 0) begin
                stk_depth--;
                r.addr = block_addr(free_stack[stk_depth]);
                r.status = ST_REUSED;
            end else if (fresh_cnt < total) begin
                r.addr = block_addr(fresh_cnt);
                fresh_cnt++;
                r.status = ST_FRESH;
            end else begin
                r.status = ST_EXHAUSTED;
            end
        end else if (total != 0 && addr != '0 && cfg_bytes != '0) begin
            region_end = {32'd0, cfg_base} + {32'd0, total} * {48'd0, cfg_bytes};
            off = addr - cfg_base;
            if (addr >= cfg_base && {32'd0, addr} < region_end &&
                off % {16'd0, cfg_bytes} == 32'd0 && stk_depth < total) begin
                free_stack[stk_depth] = off / {16'd0, cfg_bytes};
                stk_depth++;
                r.status = ST_FREE_OK;
            end
        end
        return r;
    endfunction

    task automatic wait_replies_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (reply_q.size() != 0);
    endtask

    task automatic write_pool_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_POOL_BASE:   cfg_base = val;
            REG_BLOCK_BYTES: cfg_bytes = val[BLK_BYTES_W-1:0];
            REG_POOL_BLOCKS: cfg_blocks = val[POOL_BLOCKS_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_request(input logic mode, input logic [ADDR_W-1:0] addr,
                                input logic typed, input reply_t fixed_r);
        reply_t r;
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        s_tuser <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_pool_reply(mode, addr);
        if (r.status == ST_FRESH || r.status == ST_REUSED) owned_q.push_back(r.addr);
        reply_q.push_back(typed ? fixed_r : r);
        n_items++;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // Result side: check each word taken, then pick the next ready value.
    initial begin
        reply_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected result word: block_address %h status %0d",
                           m_tdata, m_tuser);
                    err_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_tdata !== want.addr) begin
                        $error("block_address: expected %h, actual %h", want.addr, m_tdata);
                        err_cnt++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        err_cnt++;
                    end
                    if (want.status <= ST_FREE_REJECT) stat_cnt[want.status]++;
                end
            end
            if (hold_req) begin
                hold_left = 300;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                idle_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        reply_t      fixed_r;
        logic        mode;
        logic [31:0] addr;
        logic [31:0] base;
        logic [31:0] bytes;
        logic [31:0] blocks;
        int          k;
        int          j;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tbl[i].kind == ROW_CFG) begin
                wait_replies_drained();
                write_pool_reg(dir_tbl[i].reg_idx, dir_tbl[i].val);
            end else begin
                fixed_r.addr = dir_tbl[i].exp_addr;
                fixed_r.status = dir_tbl[i].exp_st;
                send_request(dir_tbl[i].mode, dir_tbl[i].val, dir_tbl[i].typed, fixed_r);
            end
        end

        fixed_r = '0;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_replies_drained();
            base = $urandom;
            if (base == 32'd0) base = 32'd1;
            bytes = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 512)
                                                : (32'd1 << $urandom_range(0, 15));
            blocks = fresh_cnt + $urandom_range(1, 24);
            case (ph)
                0: begin base = 32'd1; bytes = 32'd1; blocks = fresh_cnt + 8; end
                1: begin base = 32'hFFFF_0000; bytes = 32'd65535; blocks = fresh_cnt + 6; end
                2: blocks = 32'd0;
                3: blocks = 32'd1024;
                4: begin base = 32'hFFFF_FFFF; blocks = 32'd2047; end
                5: blocks = $urandom_range(1, 4);
                default: if ($urandom_range(0, 3) == 0) blocks = $urandom_range(1, 2047);
            endcase
            if (blocks > 32'd2047) blocks = 32'd2047;
            write_pool_reg(REG_POOL_BASE, base);
            write_pool_reg(REG_BLOCK_BYTES, bytes);
            write_pool_reg(REG_POOL_BLOCKS, blocks);
            owned_q.delete();
            tx_idle_on = (ph % 4 != 2) && (ph < PHASES - 1);
            rx_idle_on = (ph % 4 != 1) && (ph < PHASES - 1);
            if (ph == 3) begin
                tx_idle_on = 1'b0;
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                k = $urandom_range(0, 99);
                addr = $urandom;
                mode = MODE_FREE;
                if (k < 45) begin
                    mode = MODE_ALLOC;
                end else if (k < 80 && owned_q.size() > 0) begin
                    j = $urandom_range(0, owned_q.size() - 1);
                    addr = owned_q[j];
                    if ($urandom_range(0, 9) != 0) owned_q.delete(j);
                end else begin
                    case ($urandom_range(0, 5))
                        0: ;
                        1: addr = 32'd0;
                        2: addr = block_addr($urandom_range(0, pool_total() + 1));
                        3: addr = block_addr($urandom_range(0, pool_total())) + 32'd1;
                        4: addr = cfg_base - 32'd1;
                        default: addr = 32'hFFFF_FFFF;
                    endcase
                end
                send_request(mode, addr, 1'b0, fixed_r);
                if (ph > 3 && $urandom_range(0, 99) == 0) wait_replies_drained();
            end
        end

        wait_replies_drained();
        repeat (30) @(posedge aclk);
        if (reply_q.size() != 0) begin
            $error("%0d expected results never arrived", reply_q.size());
            err_cnt++;
        end
        $display("Covered %0d requests over %0d pool settings, incl. pool off, zero block size,",
                 n_items, PHASES + 6);
        $display("wrap, oversized and shrunk pools: %0d reused, %0d fresh, %0d exhausted, %0d %s",
                 stat_cnt[0], stat_cnt[1], stat_cnt[2], stat_cnt[3] + stat_cnt[4],
                 "frees checked");
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
